// ===== design/triangle_face_normal_top_defines.svh =====
// Assertion macros shared by the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tfn_pkg.sv =====
// Package: shared constants and word types of the triangle face normal block.
`default_nettype none
package tfn_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int UNIT_FRAC_BITS_DEF = 14;
    localparam int FIELD_W            = 16;
    localparam int OUT_W              = 16;
    localparam int SAT_MAG            = 32768;
    localparam int OUT_MAX            = 32767;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] c_x;
        logic signed [FIELD_W-1:0] c_y;
        logic signed [FIELD_W-1:0] c_z;
        logic                      last_triangle;
    } t_tri_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic signed [OUT_W-1:0] unit_z;
        logic                    degenerate;
        logic                    last;
    } t_norm_word;

endpackage
`default_nettype wire

// ===== design/tfn_tri_if.sv =====
// Interface: triangle input channel.
`default_nettype none
interface tfn_tri_if;
    logic               valid;
    logic               ready;
    tfn_pkg::t_tri_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tfn_norm_if.sv =====
// Interface: unit normal output channel.
`default_nettype none
interface tfn_norm_if;
    logic                valid;
    logic                ready;
    tfn_pkg::t_norm_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tfn_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module tfn_isqrt #(
    parameter int RW     = 34,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [RW];
    logic [2*RW-1:0]   r_x    [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic              pv;
        logic [2*RW-1:0]   px;
        logic [RW+1:0]     prem;
        logic [RW-1:0]     proot;
        logic [SIDE_W-1:0] pside;
        logic [RW+3:0]     cur;
        logic [RW+3:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign px    = i_rad;
            assign prem  = '0;
            assign proot = '0;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign px    = r_x[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign pside = r_side[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign cur   = {prem, px[2*RW-1 -: 2]};
        assign trial = {2'b00, proot, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {px[2*RW-3:0], 2'b00};
                r_rem[k]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
                r_root[k] <= {proot[RW-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule
`default_nettype wire

// ===== design/tfn_sdiv.sv =====
// Pipelined restoring divider for the fractional scale, one quotient bit per stage.
`default_nettype none
module tfn_sdiv #(
    parameter int RW     = 34,
    parameter int QW     = 15,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_num,
    input  logic [RW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [QW];
    logic [RW:0]       r_rem  [QW];
    logic [RW-1:0]     r_den  [QW];
    logic [QW-1:0]     r_q    [QW];
    logic [SIDE_W-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic              pv;
        logic [RW-1:0]     pden;
        logic [QW-1:0]     pq;
        logic [SIDE_W-1:0] pside;
        logic [RW:0]       cur;
        logic              ge;

        if (k == 0) begin : g_first
            // integer bit: numerator never exceeds the denominator
            assign pv    = i_valid;
            assign pden  = i_den;
            assign pq    = '0;
            assign pside = i_side;
            assign cur   = {1'b0, i_num};
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pden  = r_den[k-1];
            assign pq    = r_q[k-1];
            assign pside = r_side[k-1];
            assign cur   = {r_rem[k-1][RW-1:0], 1'b0};
        end

        assign ge = (cur >= {1'b0, pden});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (cur - {1'b0, pden}) : cur;
                r_den[k]  <= pden;
                r_q[k]    <= {pq[QW-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ===== design/triangle_face_normal_top.sv =====
// Top level: triangle face normal, cross product scaled to unit length.
//
//   channel   dir  modport   payload
//   i_tri     in   sink      vertices A, B, C (Q7.8) and last_triangle
//   o_norm    out  source    unit_x/y/z (Q1.14), degenerate, last
//
// One triangle enters per cycle while the pipe is not held. RW =
// 2*COORD_BITS + 2 is the square-root depth (one root bit per stage)
// and QW = UNIT_FRAC_BITS + 1 the divider depth.
// Reset (synchronous, active low) clears only the valid bits.
// A stall on o_norm first fills a one-word skid register with the word that
// leaves the pipe; after that the whole pipe holds, nothing is dropped.
`default_nettype none
`include "triangle_face_normal_top_defines.svh"
module triangle_face_normal_top #(
    parameter int COORD_BITS     = tfn_pkg::COORD_BITS_DEF,
    parameter int UNIT_FRAC_BITS = tfn_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfn_tri_if.sink   i_tri,
    tfn_norm_if.source o_norm
);

    localparam int DW  = COORD_BITS + 1;      // vertex difference
    localparam int PW  = 2 * DW;              // products and raw normal
    localparam int MW  = 2 * COORD_BITS + 1;  // normal component magnitude
    localparam int H   = MW / 2;              // low half for squaring
    localparam int HW  = MW - H;              // high half
    localparam int SQW = 2 * MW;              // one square
    localparam int RW  = MW + 1;              // square root
    localparam int LW  = 2 * RW;              // |n|^2
    localparam int QW  = UNIT_FRAC_BITS + 1;  // quotient

    typedef struct packed {
        logic [MW-1:0] mx;
        logic [MW-1:0] my;
        logic [MW-1:0] mz;
        logic          sx;
        logic          sy;
        logic          sz;
        logic          last;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    // pipe enable: only a full skid register holds the pipe
    logic en;
    logic r_skid_v;
    assign en          = !r_skid_v;
    assign i_tri.ready = en;

    // field taken as COORD_BITS two's complement, difference p - q
    function automatic logic signed [DW-1:0] f_diff(
        input logic [tfn_pkg::FIELD_W-1:0] p,
        input logic [tfn_pkg::FIELD_W-1:0] q
    );
        logic [COORD_BITS-1:0] ps;
        logic [COORD_BITS-1:0] qs;
        ps = COORD_BITS'(p);
        qs = COORD_BITS'(q);
        return {ps[COORD_BITS-1], ps} - {qs[COORD_BITS-1], qs};
    endfunction

    // valid bits of the front stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_tri.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // stage 1: edge vectors u = C - B, v = A - B
    logic signed [DW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic                 r_last1, r_last2, r_last3;
    // stage 2: the six cross-product terms
    logic signed [PW-1:0] r_p_uyvz, r_p_uzvy, r_p_uzvx, r_p_uxvz, r_p_uxvy, r_p_uyvx;
    // stage 3: raw normal
    logic signed [PW-1:0] r_nx, r_ny, r_nz;
    // stage 4: magnitude and sign
    t_side                r_sd4, r_sd5, r_sd6, r_sd7;
    // stage 5: half-word partial products of the squares
    logic [2*HW-1:0]      r_hh [3];
    logic [HW+H-1:0]      r_hl [3];
    logic [2*H-1:0]       r_ll [3];
    // stage 6: squares
    logic [SQW-1:0]       r_sq [3];
    // stage 7: |n|^2
    logic [LW-1:0]        r_len2;

    logic [MW-1:0] mag_in [3];
    assign mag_in[0] = r_sd4.mx;
    assign mag_in[1] = r_sd4.my;
    assign mag_in[2] = r_sd4.mz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux    <= f_diff(i_tri.data.c_x, i_tri.data.b_x);
            r_uy    <= f_diff(i_tri.data.c_y, i_tri.data.b_y);
            r_uz    <= f_diff(i_tri.data.c_z, i_tri.data.b_z);
            r_vx    <= f_diff(i_tri.data.a_x, i_tri.data.b_x);
            r_vy    <= f_diff(i_tri.data.a_y, i_tri.data.b_y);
            r_vz    <= f_diff(i_tri.data.a_z, i_tri.data.b_z);
            r_last1 <= i_tri.data.last_triangle;

            r_p_uyvz <= r_uy * r_vz;
            r_p_uzvy <= r_uz * r_vy;
            r_p_uzvx <= r_uz * r_vx;
            r_p_uxvz <= r_ux * r_vz;
            r_p_uxvy <= r_ux * r_vy;
            r_p_uyvx <= r_uy * r_vx;
            r_last2  <= r_last1;

            r_nx    <= r_p_uyvz - r_p_uzvy;
            r_ny    <= r_p_uzvx - r_p_uxvz;
            r_nz    <= r_p_uxvy - r_p_uyvx;
            r_last3 <= r_last2;

            r_sd4.mx   <= MW'(r_nx[PW-1] ? -r_nx : r_nx);
            r_sd4.my   <= MW'(r_ny[PW-1] ? -r_ny : r_ny);
            r_sd4.mz   <= MW'(r_nz[PW-1] ? -r_nz : r_nz);
            r_sd4.sx   <= r_nx[PW-1];
            r_sd4.sy   <= r_ny[PW-1];
            r_sd4.sz   <= r_nz[PW-1];
            r_sd4.last <= r_last3;

            r_sd5 <= r_sd4;
            r_sd6 <= r_sd5;
            r_sd7 <= r_sd6;

            r_len2 <= LW'(r_sq[0]) + LW'(r_sq[1]) + LW'(r_sq[2]);
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hh[c] <= mag_in[c][MW-1:H] * mag_in[c][MW-1:H];
                r_hl[c] <= mag_in[c][MW-1:H] * mag_in[c][H-1:0];
                r_ll[c] <= mag_in[c][H-1:0] * mag_in[c][H-1:0];
                r_sq[c] <= (SQW'(r_hh[c]) << (2 * H)) + (SQW'(r_hl[c]) << (H + 1))
                         + SQW'(r_ll[c]);
            end
        end
    end

    // square root of |n|^2
    logic              sq_valid;
    logic [RW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side_bits;
    t_side             sq_side;

    tfn_isqrt #(
        .RW     (RW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_rad   (r_len2),
        .i_side  (r_sd7),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    assign sq_side = t_side'(sq_side_bits);

    // three dividers in lockstep; x carries sign, degenerate and last
    logic          x_valid, y_valid, z_valid;
    logic [QW-1:0] x_quo, y_quo, z_quo;
    logic [2:0]    x_side;
    logic          y_side, z_side;

    tfn_sdiv #(.RW(RW), .QW(QW), .SIDE_W(3)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   ({1'b0, sq_side.mx}),
        .i_den   (sq_root),
        .i_side  ({sq_side.sx, (sq_root == '0), sq_side.last}),
        .o_valid (x_valid),
        .o_quo   (x_quo),
        .o_side  (x_side)
    );

    tfn_sdiv #(.RW(RW), .QW(QW), .SIDE_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   ({1'b0, sq_side.my}),
        .i_den   (sq_root),
        .i_side  (sq_side.sy),
        .o_valid (y_valid),
        .o_quo   (y_quo),
        .o_side  (y_side)
    );

    tfn_sdiv #(.RW(RW), .QW(QW), .SIDE_W(1)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   ({1'b0, sq_side.mz}),
        .i_den   (sq_root),
        .i_side  (sq_side.sz),
        .o_valid (z_valid),
        .o_quo   (z_quo),
        .o_side  (z_side)
    );

    // clamp to the signed output field; zero on a degenerate normal
    function automatic logic signed [tfn_pkg::OUT_W-1:0] f_fmt(
        input logic [QW-1:0] q,
        input logic          neg,
        input logic          deg
    );
        logic [tfn_pkg::OUT_W:0] m;
        m = (32'(q) > 32'(tfn_pkg::SAT_MAG)) ? (tfn_pkg::OUT_W+1)'(tfn_pkg::SAT_MAG)
                                              : (tfn_pkg::OUT_W+1)'(q);
        if (deg) begin
            return '0;
        end else if (neg) begin
            return tfn_pkg::OUT_W'(-m);
        end else if (m > (tfn_pkg::OUT_W+1)'(tfn_pkg::OUT_MAX)) begin
            return tfn_pkg::OUT_W'(tfn_pkg::OUT_MAX);
        end else begin
            return m[tfn_pkg::OUT_W-1:0];
        end
    endfunction

    tfn_pkg::t_norm_word tail_word;
    logic                take;

    assign tail_word.unit_x     = f_fmt(x_quo, x_side[2], x_side[1]);
    assign tail_word.unit_y     = f_fmt(y_quo, y_side, x_side[1]);
    assign tail_word.unit_z     = f_fmt(z_quo, z_side, x_side[1]);
    assign tail_word.degenerate = x_side[1];
    assign tail_word.last       = x_side[0];
    assign take                 = x_valid && en;

    // output register plus one-word skid
    logic                r_out_v;
    tfn_pkg::t_norm_word r_out;
    tfn_pkg::t_norm_word r_skid;
    logic                out_free;

    assign out_free = !r_out_v || o_norm.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else if (take) begin
                r_out   <= tail_word;
                r_out_v <= 1'b1;
            end else begin
                r_out_v <= 1'b0;
            end
        end else if (take) begin
            r_skid   <= tail_word;
            r_skid_v <= 1'b1;
        end
    end

    assign o_norm.valid = r_out_v;
    assign o_norm.data  = r_out;

    `TFN_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid word without output word")
    `TFN_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, (y_valid == x_valid) && (z_valid == x_valid), "dividers out of step")
    `TFN_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, r_out_v && r_out.degenerate, (r_out.unit_x == '0) && (r_out.unit_y == '0) && (r_out.unit_z == '0), "degenerate word with nonzero components")
    `TFN_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_v && !o_norm.ready, r_skid_v, "skid word lost under stall")

endmodule
`default_nettype wire
